// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NORST(label, prop, msg)
`endif
`endif

// ----- rtl/spae_pkg.sv -----
// Package: types, codes and sizes for the slot program evaluator.
package spae_pkg;
  localparam int SlotCount = 64;
  localparam int SlotW = 6;
  localparam int FillW = 7;
  localparam int MaxKth = 8;
  localparam int KthW = 3;
  localparam int KcntW = 4;
  localparam int ValW = 32;

  typedef enum logic [3:0] {
    OP_LOAD = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_MOD = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_TERN = 4'd8, OP_NOT = 4'd9,
    OP_KARG = 4'd10, OP_KFIN = 4'd11, OP_CLEAR = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_DIV0 = 3'd1, ERR_OVF = 3'd2, ERR_REF = 3'd3,
    ERR_FULL = 3'd4, ERR_KTH = 3'd5
  } err_t;

  typedef struct packed {
    logic [3:0]        operation;
    logic [5:0]        first_index;
    logic [5:0]        second_index;
    logic [5:0]        third_index;
    logic signed [31:0] load_value;
    logic [2:0]        rank_k;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [5:0]        slot_written;
    logic              wrote_slot;
    logic [2:0]        error_code;
  } out_item_t;

  // Request and answer of the shared divider.
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] dividend;
    logic [ValW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] quot;
    logic [ValW-1:0] rem;
  } div_rsp_t;
endpackage

// ----- rtl/spae_divider.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module spae_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  spae_pkg::div_req_t  req,
  output spae_pkg::div_rsp_t  rsp
);
  logic [spae_pkg::ValW-1:0] quot_r, quot_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [spae_pkg::ValW:0] trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quot_r[spae_pkg::ValW-1]} - {1'b0, dvs_r};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'(spae_pkg::ValW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (!trial[spae_pkg::ValW]) begin
        rem_nxt = trial[spae_pkg::ValW-1:0];
        quot_nxt = {quot_r[spae_pkg::ValW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[spae_pkg::ValW-2:0], quot_r[spae_pkg::ValW-1]};
        quot_nxt = {quot_r[spae_pkg::ValW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem = rem_r;

  `ASSERT_CLK(a_div_done_after_busy, rsp.done |-> $past(busy_r), "done without busy")
  `ASSERT_CLK(a_div_cnt_idle, !busy_r |-> cnt_r == 6'd0, "count left over")
  `ASSERT_CLK(a_div_no_restart, busy_r |-> !req.start, "divider restarted while busy")
endmodule

// ----- rtl/slot_program_alu_evaluator_unit.sv -----
// Top level: sequencer, slot memory, candidate list and shared ALU.
//
// Usage: one item is taken on the in_ channel (in_valid high, in_stall low)
// and exactly one result item is returned on the out_ channel. The block
// works on one item at a time; in_stall stays high from acceptance until
// the result is registered at the output.
// Steps from acceptance to out_valid, for all operations but div, mod and
// kth_finish: three reads through the one registered slot read port, an
// execute step and an append step; div and mod also wait for the
// one-bit-per-cycle divider when it runs; kth_finish ranks each of the n
// candidates against every candidate with the single shared comparator.
// The result sits in an output register; while out_stall is high it holds
// and the block takes the next item, stalling that item's result only if
// the previous one is still not taken.
// Reset (rst_n low, synchronous) empties the slot store and the candidate
// list through their counters; no memory clearing pass is needed.
`include "assert_macros.svh"
module slot_program_alu_evaluator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spae_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spae_pkg::out_item_t  out_data
);
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RDA   = 9'b000000010,
    ST_RDB   = 9'b000000100,
    ST_RDC   = 9'b000001000,
    ST_EXEC  = 9'b000010000,
    ST_DIVW  = 9'b000100000,
    ST_KRANK = 9'b001000000,
    ST_KNEXT = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  localparam logic [31:0] VSign = 32'h8000_0000;

  state_t state_r, state_nxt;
  spae_pkg::in_item_t item_r, item_nxt;
  logic [spae_pkg::FillW-1:0] filled_r, filled_nxt;
  logic [spae_pkg::KcntW-1:0] kcnt_r, kcnt_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic [spae_pkg::KthW-1:0] ki_r, ki_nxt, kj_r, kj_nxt;
  logic [spae_pkg::KcntW-1:0] below_r, below_nxt, same_r, same_nxt;
  spae_pkg::out_item_t res_r, res_nxt;
  logic res_ok_r, res_ok_nxt;
  logic ov_r, ov_nxt;
  spae_pkg::out_item_t od_r, od_nxt;

  // slot memory, one write and one registered read port
  logic [31:0] slots_mem [spae_pkg::SlotCount];
  logic [spae_pkg::SlotW-1:0] rd_addr;
  logic [31:0] rd_data_r;
  logic wr_en;
  logic [spae_pkg::SlotW-1:0] wr_addr;
  logic [31:0] wr_data;

  // candidate list
  logic [31:0] kcand_r [spae_pkg::MaxKth];
  logic kwr_en;

  spae_pkg::div_req_t dreq;
  spae_pkg::div_rsp_t drsp;

  spae_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  logic ref_a, ref_b, ref_c, full;
  logic [3:0] op;
  logic [31:0] kv_i, kv_j;
  logic [spae_pkg::KcntW-1:0] k_ext;
  logic out_free;

  assign op = item_r.operation;
  assign ref_a = {1'b0, item_r.first_index} < filled_r;
  assign ref_b = {1'b0, item_r.second_index} < filled_r;
  assign ref_c = {1'b0, item_r.third_index} < filled_r;
  assign full = filled_r == spae_pkg::FillW'(spae_pkg::SlotCount);
  assign kv_i = kcand_r[ki_r];
  assign kv_j = kcand_r[kj_r];
  assign k_ext = {1'b0, item_r.rank_k};
  assign out_free = !ov_r || !out_stall;
  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    filled_nxt = filled_r;
    kcnt_nxt = kcnt_r;
    a_nxt = a_r;
    b_nxt = b_r;
    ki_nxt = ki_r;
    kj_nxt = kj_r;
    below_nxt = below_r;
    same_nxt = same_r;
    res_nxt = res_r;
    res_ok_nxt = res_ok_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    rd_addr = item_r.first_index;
    wr_en = 1'b0;
    wr_addr = filled_r[spae_pkg::SlotW-1:0];
    wr_data = res_r.result_value;
    kwr_en = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = mag(a_r);
    dreq.divisor = mag(b_r);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          state_nxt = ST_RDA;
        end
      end
      // issue slot reads, one per cycle; data lands in the cycle after the read
      ST_RDA: begin
        rd_addr = item_r.first_index;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        rd_addr = item_r.second_index;
        a_nxt = rd_data_r;
        state_nxt = ST_RDC;
      end
      ST_RDC: begin
        rd_addr = item_r.third_index;
        b_nxt = rd_data_r;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_nxt = '0;
        res_ok_nxt = 1'b0;
        state_nxt = ST_DONE;
        case (op)
          spae_pkg::OP_LOAD: begin
            res_nxt.result_value = item_r.load_value;
            res_ok_nxt = 1'b1;
          end
          spae_pkg::OP_ADD, spae_pkg::OP_SUB, spae_pkg::OP_MUL,
          spae_pkg::OP_AND, spae_pkg::OP_OR: begin
            if (!ref_a || !ref_b) res_nxt.error_code = spae_pkg::ERR_REF;
            else begin
              res_ok_nxt = 1'b1;
              case (op)
                spae_pkg::OP_ADD: res_nxt.result_value = a_r + b_r;
                spae_pkg::OP_SUB: res_nxt.result_value = a_r - b_r;
                spae_pkg::OP_MUL: res_nxt.result_value = a_r * b_r;
                spae_pkg::OP_AND: res_nxt.result_value = {31'd0, a_r != 0 && b_r != 0};
                default: res_nxt.result_value = {31'd0, a_r != 0 || b_r != 0};
              endcase
            end
          end
          spae_pkg::OP_DIV, spae_pkg::OP_MOD: begin
            if (!ref_a || !ref_b) res_nxt.error_code = spae_pkg::ERR_REF;
            else if (b_r == 32'd0) res_nxt.error_code = spae_pkg::ERR_DIV0;
            else if (a_r == VSign && b_r == 32'hFFFF_FFFF)
              res_nxt.error_code = spae_pkg::ERR_OVF;
            else begin
              dreq.start = 1'b1;
              state_nxt = ST_DIVW;
            end
          end
          spae_pkg::OP_TERN: begin
            if (!ref_a || !ref_b || !ref_c) res_nxt.error_code = spae_pkg::ERR_REF;
            else begin
              res_ok_nxt = 1'b1;
              res_nxt.result_value = (a_r != 0) ? b_r : rd_data_r;
            end
          end
          spae_pkg::OP_NOT: begin
            if (!ref_a) res_nxt.error_code = spae_pkg::ERR_REF;
            else begin
              res_ok_nxt = 1'b1;
              res_nxt.result_value = {31'd0, a_r == 0};
            end
          end
          spae_pkg::OP_KARG: begin
            if (!ref_a) res_nxt.error_code = spae_pkg::ERR_REF;
            else if (kcnt_r == spae_pkg::KcntW'(spae_pkg::MaxKth))
              res_nxt.error_code = spae_pkg::ERR_KTH;
            else begin
              kwr_en = 1'b1;
              kcnt_nxt = kcnt_r + 1'b1;
              res_nxt.result_value = a_r;
            end
          end
          spae_pkg::OP_KFIN: begin
            if (kcnt_r == '0 || k_ext >= kcnt_r) begin
              res_nxt.error_code = spae_pkg::ERR_KTH;
              kcnt_nxt = '0;
            end else begin
              ki_nxt = '0;
              kj_nxt = '0;
              below_nxt = '0;
              same_nxt = '0;
              state_nxt = ST_KRANK;
            end
          end
          spae_pkg::OP_CLEAR: begin
            filled_nxt = '0;
            kcnt_nxt = '0;
          end
          default: ;
        endcase
      end
      ST_DIVW: begin
        if (drsp.done) begin
          res_ok_nxt = 1'b1;
          if (op == spae_pkg::OP_DIV)
            res_nxt.result_value = ((a_r ^ b_r) & VSign) != 0 ? 32'd0 - drsp.quot
                                                                : drsp.quot;
          else
            res_nxt.result_value = a_r[31] ? 32'd0 - drsp.rem : drsp.rem;
          state_nxt = ST_DONE;
        end
      end
      // rank candidate ki against each candidate kj with the one comparator
      ST_KRANK: begin
        if ($signed(kv_j) < $signed(kv_i)) below_nxt = below_r + 1'b1;
        else if (kv_j == kv_i) same_nxt = same_r + 1'b1;
        if ({1'b0, kj_r} == kcnt_r - 1'b1) state_nxt = ST_KNEXT;
        else kj_nxt = kj_r + 1'b1;
      end
      ST_KNEXT: begin
        if (below_r <= k_ext && k_ext < below_r + same_r) begin
          res_ok_nxt = 1'b1;
          res_nxt.result_value = kv_i;
          kcnt_nxt = '0;
          state_nxt = ST_DONE;
        end else if ({1'b0, ki_r} == kcnt_r - 1'b1) begin
          res_nxt.error_code = spae_pkg::ERR_KTH;
          kcnt_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          ki_nxt = ki_r + 1'b1;
          kj_nxt = '0;
          below_nxt = '0;
          same_nxt = '0;
          state_nxt = ST_KRANK;
        end
      end
      // append if asked, then hand the result to the output register
      ST_DONE: begin
        if (out_free) begin
          od_nxt = res_r;
          if (res_ok_r) begin
            if (full) begin
              od_nxt = '0;
              od_nxt.error_code = spae_pkg::ERR_FULL;
            end else begin
              wr_en = 1'b1;
              od_nxt.slot_written = filled_r[spae_pkg::SlotW-1:0];
              od_nxt.wrote_slot = 1'b1;
              filled_nxt = filled_r + 1'b1;
            end
          end
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots_mem[wr_addr] <= wr_data;
    rd_data_r <= slots_mem[rd_addr];
    if (kwr_en) kcand_r[kcnt_r[spae_pkg::KthW-1:0]] <= a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      filled_r <= '0;
      kcnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      filled_r <= filled_nxt;
      kcnt_r <= kcnt_nxt;
      ov_r <= ov_nxt;
    end
    item_r <= item_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    ki_r <= ki_nxt;
    kj_r <= kj_nxt;
    below_r <= below_nxt;
    same_r <= same_nxt;
    res_r <= res_nxt;
    res_ok_r <= res_ok_nxt;
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

  `ASSERT_CLK(a_fill_bound, filled_r <= spae_pkg::FillW'(spae_pkg::SlotCount), "store overfilled")
  `ASSERT_CLK(a_kcnt_bound, kcnt_r <= spae_pkg::KcntW'(spae_pkg::MaxKth), "too many candidates")
  `ASSERT_CLK(a_out_hold, ov_r && out_stall |=> ov_r && $stable(od_r), "result lost while stalled")
  `ASSERT_CLK(a_write_out, wr_en |=> ov_r && od_r.wrote_slot, "append without result")
  `ASSERT_CLK(a_one_item, state_r != ST_IDLE |-> in_stall, "item taken while busy")
endmodule
